@@ src/timed_event_slot_queue_unit_defines.svh @@
// Assertion macros shared by the queue modules.
// They sample on clk and are disabled while arst_n is low.
`ifndef TIMED_EVENT_SLOT_QUEUE_UNIT_DEFINES_SVH
`define TIMED_EVENT_SLOT_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TESQ_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tesq: same-cycle check failed");
`define TESQ_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tesq: next-cycle check failed");
`else
`define TESQ_ASSERT_IMP(name, ante, cons)
`define TESQ_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ src/tesq_pkg.sv @@
package tesq_pkg;

	localparam int NUM_SLOTS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int DUE_W       = 32;
	localparam int CODE_W      = 8;
	localparam int ENTRY_W     = DUE_W + CODE_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_OUT_MID,
		ST_FINAL,
		ST_OUT_LAST
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // latch input word
		logic exec;        // run insert / clear / ignored op
		logic scan_start;  // reset scan, read slot 0
		logic check;       // evaluate current slot
		logic advance;     // step to next slot, read it
		logic final_load;  // load closing result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
		logic hit;
		logic pend_vld;
		logic idx_last;
	} sts_t;

endpackage

@@ src/tesq_ram.sv @@
module tesq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/tesq_ctrl.sv @@
`include "timed_event_slot_queue_unit_defines.svh"

module tesq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tesq_pkg::sts_t  sts,
	output tesq_pkg::cmd_t  cmd
);

	import tesq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = sts.is_tick ? ST_CHECK : ST_OUT_LAST;
			end
			ST_CHECK: begin
				priority if (sts.hit && sts.pend_vld) state_d = ST_OUT_MID;
				else if (sts.idx_last)                state_d = ST_FINAL;
				else                                  state_d = ST_CHECK;
			end
			ST_OUT_MID: begin
				if (out_ready) state_d = sts.idx_last ? ST_FINAL : ST_CHECK;
			end
			ST_FINAL: begin
				state_d = ST_OUT_LAST;
			end
			ST_OUT_LAST: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.scan_start = sts.is_tick;
				cmd.exec       = !sts.is_tick;
			end
			ST_CHECK: begin
				cmd.check   = 1'b1;
				cmd.advance = !(sts.hit && sts.pend_vld) && !sts.idx_last;
			end
			ST_OUT_MID: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready && !sts.idx_last;
			end
			ST_FINAL: begin
				cmd.final_load = 1'b1;
			end
			ST_OUT_LAST: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// one word in flight: never taking input while a result is offered
	`TESQ_ASSERT_IMP(a_ready_excl, in_ready, !out_valid)
	`TESQ_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid)

endmodule

@@ src/tesq_dp.sv @@
`include "timed_event_slot_queue_unit_defines.svh"

module tesq_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  tesq_pkg::cmd_t  cmd,
	output tesq_pkg::sts_t  sts,
	input  logic [1:0]      opcode,
	input  logic [15:0]     sound_code,
	input  logic [31:0]     time_value,
	output logic            accepted,
	output logic            play_valid,
	output logic [7:0]      play_code,
	output logic            last
);

	import tesq_pkg::*;

	logic [1:0]           op_q;
	logic [CODE_W-1:0]    code_q;
	logic [DUE_W-1:0]     time_q;
	logic [NUM_SLOTS-1:0] occ_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_vld_q;
	logic [CODE_W-1:0]    pend_code_q;
	logic                 accepted_q;
	logic                 play_valid_q;
	logic [CODE_W-1:0]    play_code_q;
	logic                 last_q;

	logic                 free_found;
	logic [SLOT_W-1:0]    free_idx;
	logic                 ins_wr;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_addr;
	logic [ENTRY_W-1:0]   rd_data;
	logic [DUE_W-1:0]     rd_due;
	logic [CODE_W-1:0]    rd_code;
	logic                 hit;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign ins_wr  = cmd.exec && (op_q == OP_INSERT) && free_found;
	assign rd_en   = cmd.scan_start || cmd.advance;
	assign rd_addr = cmd.scan_start ? '0 : idx_q + SLOT_W'(1);

	tesq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ins_wr),
		.wr_addr (free_idx),
		.wr_data ({time_q, code_q}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_due  = rd_data[ENTRY_W-1:CODE_W];
	assign rd_code = rd_data[CODE_W-1:0];
	// occupied implies a non-zero due time
	assign hit = occ_q[idx_q] && (rd_due < time_q) && (cnt_q < CNT_W'(MAX_RESULTS));

	assign sts.is_tick  = (op_q == OP_TICK);
	assign sts.hit      = hit;
	assign sts.pend_vld = pend_vld_q;
	assign sts.idx_last = (idx_q == SLOT_W'(NUM_SLOTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			code_q <= sound_code[CODE_W-1:0];
			time_q <= time_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.exec && (op_q == OP_CLEAR)) begin
			occ_q <= '0;
		end else if (ins_wr) begin
			occ_q[free_idx] <= (time_q != '0);
		end else if (cmd.check && hit) begin
			occ_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				idx_q      <= '0;
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end else begin
				if (cmd.advance) idx_q <= idx_q + SLOT_W'(1);
				if (cmd.check && hit) begin
					cnt_q      <= cnt_q + CNT_W'(1);
					pend_vld_q <= 1'b1;
				end else if (cmd.final_load) begin
					pend_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check && hit) pend_code_q <= rd_code;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			accepted_q   <= ins_wr;
			play_valid_q <= 1'b0;
			play_code_q  <= '0;
			last_q       <= 1'b1;
		end else if (cmd.check && hit && pend_vld_q) begin
			accepted_q   <= 1'b0;
			play_valid_q <= 1'b1;
			play_code_q  <= pend_code_q;
			last_q       <= 1'b0;
		end else if (cmd.final_load) begin
			accepted_q   <= 1'b0;
			play_valid_q <= pend_vld_q;
			play_code_q  <= pend_vld_q ? pend_code_q : '0;
			last_q       <= 1'b1;
		end
	end

	assign accepted   = accepted_q;
	assign play_valid = play_valid_q;
	assign play_code  = play_code_q;
	assign last       = last_q;

	`TESQ_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CNT_W'(MAX_RESULTS))
	`TESQ_ASSERT_NXT(a_clear_frees, cmd.exec && (op_q == OP_CLEAR), occ_q == '0)

endmodule

@@ src/timed_event_slot_queue_unit.sv @@
// Timed event slot queue: a table of NUM_SLOTS slots, each a due time and a sound code.
// Input channel (in_valid/in_ready): one word carries opcode, sound_code and time_value.
//   insert stores the word in the lowest free slot (time zero leaves it free),
//   tick plays every occupied slot due strictly before time_value, clear frees all.
// Output channel (out_valid/out_ready): result words, the final one of each input
//   word flagged by last. Insert, clear and unused opcodes give one word, loaded
//   in the execute step after acceptance. A tick gives one word per due slot (at most
//   MAX_RESULTS), or one empty word; the scan walks the slot RAM one slot per clock
//   while no result word is offered, and the last word of a tick is loaded only
//   after the scan has passed the last slot.
// One input word is worked on at a time: in_ready is high only once the previous
//   word's results have all been taken. A stalled receiver freezes the scan.
// Reset: occupancy flags clear at once, so every slot reads as free; no
//   clearing pass over the RAM is needed.
module timed_event_slot_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] sound_code,
	input  logic [31:0] time_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        play_valid,
	output logic [7:0]  play_code,
	output logic        last
);

	import tesq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, execute or scan, hand out result words
	tesq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot table, occupancy, scan pointer and result register
	tesq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.sound_code (sound_code),
		.time_value (time_value),
		.accepted   (accepted),
		.play_valid (play_valid),
		.play_code  (play_code),
		.last       (last)
	);

endmodule

@@ tb/sv/timed_event_slot_queue_unit_test.sv @@
`timescale 1ns / 1ps

module timed_event_slot_queue_unit_test;
	import tesq_pkg::*;

	// opcode three has no function; the block must answer it with one empty word
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one result word as seen on the output channel
	typedef struct packed {
		logic       accepted;
		logic       play_valid;
		logic [7:0] play_code;
		logic       last;
	} result_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [15:0] sound_code;
	logic [31:0] time_value;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        accepted;
	logic        play_valid;
	logic [7:0]  play_code;
	logic        last;

	// predicted slot table: due time zero means the slot is free
	logic [31:0] slot_due[NUM_SLOTS];
	logic [7:0]  slot_code[NUM_SLOTS];

	// words still owed by the block, oldest first
	result_word_t owed_words[$];
	result_word_t owed_head;

	int          mismatch_count = 0;
	int          send_idle_pct  = 0;
	int          recv_idle_pct  = 0;
	int          hold_request   = 0;
	int          hold_left      = 0;
	logic [31:0] clock_ms       = 32'd1000;

	timed_event_slot_queue_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.sound_code(sound_code),
		.time_value(time_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.play_valid(play_valid),
		.play_code (play_code),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop. The slowest legal run (every tick spilling a full table into a
	// receiver that is idle 65 percent of the time, plus the long hold-off) stays
	// well inside this time limit.
	initial begin
		#5_000_000;
		$display("timed_event_slot_queue_unit verification failed");
		$finish;
	end

	// Receiver: random ready at the falling edge, or a counted hold-off when a
	// test asks for one.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Slot table predictor: works out every word an accepted input word causes
	// and updates the table as the block should.
	task automatic predict_slots(input logic [1:0] op, input logic [15:0] code,
		input logic [31:0] t);
		result_word_t spill[MAX_RESULTS];
		result_word_t w;
		int           n;
		logic         found;
		w = '0;
		w.last = 1'b1;
		case (op)
			OP_INSERT: begin
				found = 1'b0;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!found && slot_due[i] == 32'd0) begin
						// time zero writes the code but the slot reads free again
						slot_due[i] = t;
						slot_code[i] = code[7:0];
						found = 1'b1;
					end
				end
				w.accepted = found;
				owed_words.push_back(w);
			end
			OP_TICK: begin
				n = 0;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					// strictly earlier than the tick time; equal is not yet due
					if (n < MAX_RESULTS && slot_due[i] != 32'd0 && slot_due[i] < t) begin
						spill[n] = '0;
						spill[n].play_valid = 1'b1;
						spill[n].play_code = slot_code[i];
						slot_due[i] = 32'd0;
						n++;
					end
				end
				if (n == 0) begin
					owed_words.push_back(w);
				end else begin
					spill[n - 1].last = 1'b1;
					for (int i = 0; i < n; i++)
						owed_words.push_back(spill[i]);
				end
			end
			default: begin
				if (op == OP_CLEAR) begin
					for (int i = 0; i < NUM_SLOTS; i++)
						slot_due[i] = 32'd0;
				end
				owed_words.push_back(w);
			end
		endcase
	endtask

	// Offer one word after a random gap; valid stays up until accepted.
	task automatic send_word(input logic [1:0] op, input logic [15:0] code,
		input logic [31:0] t);
		int gap;
		@(negedge clk);
		gap = 0;
		while (gap < 40 && $urandom_range(99, 0) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		sound_code = code;
		time_value = t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_slots(op, code, t);
	endtask

	// Drop valid and wait until every owed word has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (owed_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Output checker: every word taken is matched against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_words.size() == 0) begin
				$display("%0t: unexpected word, expected none,", $time,
					" got acc=%0b play=%0b code=%0h last=%0b",
					accepted, play_valid, play_code, last);
				mismatch_count++;
			end else begin
				owed_head = owed_words.pop_front();
				compare_field("accepted", {7'd0, owed_head.accepted}, {7'd0, accepted});
				compare_field("play_valid", {7'd0, owed_head.play_valid}, {7'd0, play_valid});
				compare_field("play_code", owed_head.play_code, play_code);
				compare_field("last", {7'd0, owed_head.last}, {7'd0, last});
			end
		end
	end

	// ticks against an empty table, at both ends of the time range
	task automatic test_empty_ticks();
		send_word(OP_TICK, 16'h0000, 32'h0000_0000);
		send_word(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// time-zero insert, the equal-time boundary and the low-byte truncation
	task automatic test_insert_edges();
		send_word(OP_INSERT, 16'hFFFF, 32'h0000_0000);
		send_word(OP_INSERT, 16'h1234, 32'd100);
		send_word(OP_TICK, 16'h0000, 32'd100);
		send_word(OP_TICK, 16'h0000, 32'd101);
		drain_results();
	endtask

	// opcode three must leave the table alone
	task automatic test_unused_opcode();
		send_word(OP_INSERT, 16'hA5C3, 32'd7);
		send_word(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_TICK, 16'h0000, 32'd8);
		drain_results();
	endtask

	// fill every slot, reject one more, spill all but the never-due one, clear
	task automatic test_full_table();
		for (int i = 0; i < NUM_SLOTS; i++)
			send_word(OP_INSERT, 16'hFF00 | 16'(i),
				(i == NUM_SLOTS - 1) ? 32'hFFFF_FFFF : 32'(i + 1));
		send_word(OP_INSERT, 16'h00EE, 32'd5);
		send_word(OP_TICK, 16'h0000, 32'hFFFF_FFFF);
		send_word(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the first result word blocks and the input side stalls behind it.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 300;
		for (int k = 0; k < 6; k++)
			send_word(OP_INSERT, 16'($urandom), clock_ms + 32'(k + 1));
		clock_ms += 32'd10;
		send_word(OP_TICK, 16'($urandom), clock_ms);
		drain_results();
	endtask

	// Mostly a running clock: inserts a little ahead of it and ticks that walk
	// it forward. Now and then a full burst, a clear, opcode three or noise.
	task automatic test_random_traffic(input int n_words, input int snd_pct,
		input int rcv_pct);
		int          sent;
		int          pick;
		logic [31:0] due;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_words) begin
			pick = $urandom_range(99, 0);
			if (pick < 55) begin
				due = ($urandom_range(19, 0) == 0) ? 32'd0 : clock_ms + $urandom_range(20, 0);
				send_word(OP_INSERT, 16'($urandom), due);
				sent++;
			end else if (pick < 80) begin
				clock_ms += $urandom_range(8, 0);
				send_word(OP_TICK, 16'($urandom), clock_ms);
				sent++;
			end else if (pick < 85) begin
				send_word(OP_CLEAR, 16'($urandom), $urandom);
				sent++;
			end else if (pick < 88) begin
				send_word(OP_UNUSED, 16'($urandom), $urandom);
			end else if (pick < 95) begin
				send_word($urandom_range(1, 0) ? OP_INSERT : OP_TICK, 16'($urandom), $urandom);
				sent++;
			end else begin
				// empty table, fill it, then one tick that spills every slot
				send_word(OP_CLEAR, 16'($urandom), $urandom);
				for (int i = 0; i < NUM_SLOTS; i++)
					send_word(OP_INSERT, 16'($urandom), clock_ms + $urandom_range(5, 1));
				clock_ms += 32'd8;
				send_word(OP_TICK, 16'($urandom), clock_ms);
				sent += NUM_SLOTS + 2;
			end
		end
		drain_results();
	endtask

	initial begin
		in_valid = 1'b0;
		opcode = OP_INSERT;
		sound_code = 16'd0;
		time_value = 32'd0;
		arst_n = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_due[i] = 32'd0;
			slot_code[i] = 8'd0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 24;
		recv_idle_pct = 65;
		test_empty_ticks();
		test_insert_edges();
		test_unused_opcode();
		test_full_table();
		test_backpressure();
		test_random_traffic(40, 24, 65);
		test_random_traffic(40, 65, 24);
		test_random_traffic(40, 0, 0);

		// let any stray word show up before the verdict
		repeat (4 * NUM_SLOTS) @(posedge clk);
		if (owed_words.size() != 0) begin
			$display("%0t: words outstanding, expected 0, got %0d", $time, owed_words.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("timed_event_slot_queue_unit verification clean");
		end else begin
			$display("timed_event_slot_queue_unit verification failed");
		end
		$finish;
	end

endmodule
